/* src/uap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uap_pkg
// Shared types, constants and character helpers for the URL authority parser.
// ----------------------------------------------------------------------------
package uap_pkg;

  localparam int MAX_URL_BYTES_DEF = 2048;
  localparam int OUT_POS_W         = 12;
  localparam int SCHEME_KEEP       = 5;
  localparam int SCHEME_LEN_MAX    = 6;
  localparam int PORT_W            = 17;
  localparam int PORT_MAX          = 65535;
  localparam int PORT_SAT          = 65536;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_HOST_START,
    PH_HOST,
    PH_V6,
    PH_AFTER_V6,
    PH_PORT,
    PH_PATH,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_URL,
    ST_BAD_SCHEME,
    ST_CREDENTIALS
  } status_t;

  typedef struct packed {
    phase_t                          phase;
    logic [SCHEME_KEEP-1:0][7:0]     scheme_chars;
    logic [2:0]                      scheme_length;
    logic                            scheme_overflow;
    logic                            at_sign_seen;
    logic                            port_digit_seen;
    logic                            bad_flag;
    logic                            too_long;
  } scan_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic host_char_ok(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"], ["0":"9"], CH_DASH, CH_DOT, CH_UNDER, CH_COLON});
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {["A":"Z"]}) ? c + 8'd32 : c;
  endfunction

  // authority closing checks: open bracket, empty host, bad port
  function automatic logic auth_bad(input phase_t ph, input logic count_zero,
                                    input logic digit_seen, input logic port_zero);
    return (ph == PH_V6) || count_zero || ((ph == PH_PORT) && (!digit_seen || port_zero));
  endfunction

endpackage

/* src/uap_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uap_scan
// Per-byte parse state: holds the running state and works out the state
// after the current beat.
// ----------------------------------------------------------------------------
module uap_scan #(
  parameter int MAX_URL_BYTES = uap_pkg::MAX_URL_BYTES_DEF,
  parameter int POS_W         = $clog2(MAX_URL_BYTES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [7:0]                  url_byte,
  input  logic                        last_byte,
  input  logic                        empty_url,
  output uap_pkg::scan_t              scan_next,
  output logic [POS_W-1:0]            pos_next,
  output logic [POS_W-1:0]            host_begin_next,
  output logic [POS_W-1:0]            host_count_next,
  output logic [POS_W-1:0]            path_begin_next,
  output logic [uap_pkg::PORT_W-1:0]  port_value_next
);

  localparam int PW = uap_pkg::PORT_W;

  uap_pkg::scan_t   scan;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] host_begin;
  logic [POS_W-1:0] host_count;
  logic [POS_W-1:0] path_begin;
  logic [PW-1:0]    port_value;
  logic [15:0]      recent;
  logic [15:0]      recent_next;

  logic [7:0]       c;
  logic [PW+3:0]    port_calc;
  logic [POS_W-1:0] scheme_end;

  assign c          = url_byte;
  assign scheme_end = pos - POS_W'(2);
  assign port_calc  = {port_value, 3'b000} + {2'b00, port_value, 1'b0}
                    + (PW+4)'(c - uap_pkg::CH_ZERO);

  always_comb begin
    scan_next       = scan;
    pos_next        = pos;
    host_begin_next = host_begin;
    host_count_next = host_count;
    path_begin_next = path_begin;
    port_value_next = port_value;
    recent_next     = recent;
    if (!empty_url) begin
      if (pos >= POS_W'(MAX_URL_BYTES)) begin
        scan_next.too_long = 1'b1;
      end else begin
        recent_next = {recent[7:0], c};
        pos_next    = pos + POS_W'(1);
        if (scan.phase == uap_pkg::PH_SCHEME) begin
          if (pos < POS_W'(uap_pkg::SCHEME_KEEP)) begin
            scan_next.scheme_chars[pos[2:0]] = uap_pkg::to_lower(c);
          end
          if ((c == uap_pkg::CH_SLASH) && (recent[7:0] == uap_pkg::CH_SLASH) &&
              (recent[15:8] == uap_pkg::CH_COLON) && (pos >= POS_W'(2))) begin
            if (scheme_end > POS_W'(uap_pkg::SCHEME_LEN_MAX)) begin
              scan_next.scheme_overflow = 1'b1;
            end else begin
              scan_next.scheme_length = scheme_end[2:0];
            end
            scan_next.phase = uap_pkg::PH_HOST_START;
          end
        end else if (scan.phase != uap_pkg::PH_PATH) begin
          if (c inside {uap_pkg::CH_SLASH, uap_pkg::CH_QUEST, uap_pkg::CH_HASH}) begin
            if (uap_pkg::auth_bad(scan.phase, host_count == '0, scan.port_digit_seen,
                                  port_value == '0)) begin
              scan_next.bad_flag = 1'b1;
            end
            path_begin_next = pos;
            scan_next.phase = uap_pkg::PH_PATH;
          end else if (c == uap_pkg::CH_AT) begin
            scan_next.at_sign_seen = 1'b1;
          end else begin
            case (scan.phase)
              uap_pkg::PH_HOST_START, uap_pkg::PH_HOST: begin
                if ((scan.phase == uap_pkg::PH_HOST_START) && (c == uap_pkg::CH_LBRACK)) begin
                  host_begin_next = pos + POS_W'(1);
                  scan_next.phase = uap_pkg::PH_V6;
                end else begin
                  if (scan.phase == uap_pkg::PH_HOST_START) begin
                    host_begin_next = pos;
                  end
                  if (c == uap_pkg::CH_COLON) begin
                    scan_next.phase = uap_pkg::PH_PORT;
                  end else begin
                    scan_next.phase = uap_pkg::PH_HOST;
                    if (!uap_pkg::host_char_ok(c)) begin
                      scan_next.bad_flag = 1'b1;
                    end
                    host_count_next = host_count + POS_W'(1);
                  end
                end
              end
              uap_pkg::PH_V6: begin
                if (c == uap_pkg::CH_RBRACK) begin
                  scan_next.phase = uap_pkg::PH_AFTER_V6;
                end else begin
                  if (!uap_pkg::host_char_ok(c)) begin
                    scan_next.bad_flag = 1'b1;
                  end
                  host_count_next = host_count + POS_W'(1);
                end
              end
              uap_pkg::PH_AFTER_V6: begin
                if (c == uap_pkg::CH_COLON) begin
                  scan_next.phase = uap_pkg::PH_PORT;
                end else begin
                  scan_next.bad_flag = 1'b1;
                  scan_next.phase    = uap_pkg::PH_SKIP;
                end
              end
              uap_pkg::PH_PORT: begin
                if (uap_pkg::is_digit(c)) begin
                  scan_next.port_digit_seen = 1'b1;
                  // saturate one past the legal maximum
                  if (port_calc > (PW+4)'(uap_pkg::PORT_MAX)) begin
                    scan_next.bad_flag = 1'b1;
                    port_value_next    = PW'(uap_pkg::PORT_SAT);
                  end else begin
                    port_value_next = port_calc[PW-1:0];
                  end
                end else begin
                  scan_next.bad_flag = 1'b1;
                  scan_next.phase    = uap_pkg::PH_SKIP;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && (empty_url || last_byte))) begin
      scan       <= '{phase: uap_pkg::PH_SCHEME, default: '0};
      pos        <= '0;
      host_begin <= '0;
      host_count <= '0;
      path_begin <= '0;
      port_value <= '0;
      recent     <= '0;
    end else if (take) begin
      scan       <= scan_next;
      pos        <= pos_next;
      host_begin <= host_begin_next;
      host_count <= host_count_next;
      path_begin <= path_begin_next;
      port_value <= port_value_next;
      recent     <= recent_next;
    end
  end

endmodule

/* src/uap_judge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uap_judge
// End-of-URL checks: scheme match, precedence of failures and the result
// fields, worked out from the state after the final beat.
// ----------------------------------------------------------------------------
module uap_judge #(
  parameter int POS_W = 12
) (
  input  uap_pkg::scan_t                  scan,
  input  logic [POS_W-1:0]                pos,
  input  logic [POS_W-1:0]                host_begin,
  input  logic [POS_W-1:0]                host_count,
  input  logic [POS_W-1:0]                path_begin,
  input  logic [uap_pkg::PORT_W-1:0]      port_value,
  output uap_pkg::status_t                status,
  output logic                            secure,
  output logic [15:0]                     port_number,
  output logic [uap_pkg::OUT_POS_W-1:0]   host_offset,
  output logic [uap_pkg::OUT_POS_W-1:0]   host_length,
  output logic [uap_pkg::OUT_POS_W-1:0]   path_offset
);

  localparam int OW = uap_pkg::OUT_POS_W;

  logic http_hit;
  logic https_hit;
  logic http4;
  logic auth_fail;

  assign http4 = (scan.scheme_chars[0] == "h") && (scan.scheme_chars[1] == "t") &&
                 (scan.scheme_chars[2] == "t") && (scan.scheme_chars[3] == "p");
  assign http_hit  = !scan.scheme_overflow && (scan.scheme_length == 3'd4) && http4;
  assign https_hit = !scan.scheme_overflow && (scan.scheme_length == 3'd5) && http4 &&
                     (scan.scheme_chars[4] == "s");
  assign auth_fail = (scan.phase != uap_pkg::PH_PATH) &&
                     uap_pkg::auth_bad(scan.phase, host_count == '0, scan.port_digit_seen,
                                       port_value == '0);

  always_comb begin
    if (scan.too_long || (pos == '0) || (scan.phase == uap_pkg::PH_SCHEME)) begin
      status = uap_pkg::ST_BAD_URL;
    end else if (!scan.scheme_overflow && (scan.scheme_length == 3'd0)) begin
      status = uap_pkg::ST_BAD_URL;
    end else if (!(https_hit || http_hit)) begin
      status = uap_pkg::ST_BAD_SCHEME;
    end else if (scan.at_sign_seen) begin
      status = uap_pkg::ST_CREDENTIALS;
    end else if (scan.bad_flag || auth_fail) begin
      status = uap_pkg::ST_BAD_URL;
    end else begin
      status = uap_pkg::ST_OK;
    end
  end

  always_comb begin
    secure      = 1'b0;
    port_number = '0;
    host_offset = '0;
    host_length = '0;
    path_offset = '0;
    if (status == uap_pkg::ST_OK) begin
      secure      = https_hit;
      port_number = port_value[15:0];
      host_offset = OW'(host_begin);
      host_length = OW'(host_count);
      path_offset = (scan.phase == uap_pkg::PH_PATH) ? OW'(path_begin) : OW'(pos);
    end
  end

endmodule

/* src/url_authority_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_authority_parser
// Checks an absolute http/https URL streamed one byte per beat and reports
// status, scheme security, port, host position/length and path start.
// ----------------------------------------------------------------------------
// Takes one URL byte every clock cycle while in_ready is high, with no gaps
// between URLs; the parse state advances on each accepted beat. On the beat
// that ends a URL (last_byte or empty_url) the result is checked in the same
// cycle and lands in the output register, visible in the next cycle. Input
// is stalled only while an unread result sits there and out_ready is low.
// Bytes past MAX_URL_BYTES are dropped and the URL is reported as bad.
module url_authority_parser #(
  parameter int MAX_URL_BYTES = uap_pkg::MAX_URL_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      url_byte,
  input  logic                            last_byte,
  input  logic                            empty_url,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic                            secure,
  output logic [15:0]                     port_number,
  output logic [uap_pkg::OUT_POS_W-1:0]   host_offset,
  output logic [uap_pkg::OUT_POS_W-1:0]   host_length,
  output logic [uap_pkg::OUT_POS_W-1:0]   path_offset
);

  localparam int POS_W = $clog2(MAX_URL_BYTES + 1);
  localparam int OW    = uap_pkg::OUT_POS_W;

  logic                        take;
  logic                        url_end;
  uap_pkg::scan_t              scan_next;
  logic [POS_W-1:0]            pos_next;
  logic [POS_W-1:0]            host_begin_next;
  logic [POS_W-1:0]            host_count_next;
  logic [POS_W-1:0]            path_begin_next;
  logic [uap_pkg::PORT_W-1:0]  port_value_next;

  uap_pkg::status_t            res_status;
  logic                        res_secure;
  logic [15:0]                 res_port;
  logic [OW-1:0]               res_host_offset;
  logic [OW-1:0]               res_host_length;
  logic [OW-1:0]               res_path_offset;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign url_end  = take && (empty_url || last_byte);

  uap_scan #(
    .MAX_URL_BYTES (MAX_URL_BYTES),
    .POS_W         (POS_W)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .url_byte        (url_byte),
    .last_byte       (last_byte),
    .empty_url       (empty_url),
    .scan_next       (scan_next),
    .pos_next        (pos_next),
    .host_begin_next (host_begin_next),
    .host_count_next (host_count_next),
    .path_begin_next (path_begin_next),
    .port_value_next (port_value_next)
  );

  uap_judge #(
    .POS_W (POS_W)
  ) u_judge (
    .scan        (scan_next),
    .pos         (pos_next),
    .host_begin  (host_begin_next),
    .host_count  (host_count_next),
    .path_begin  (path_begin_next),
    .port_value  (port_value_next),
    .status      (res_status),
    .secure      (res_secure),
    .port_number (res_port),
    .host_offset (res_host_offset),
    .host_length (res_host_length),
    .path_offset (res_path_offset)
  );

  // result register, refilled in the same cycle it is read
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (url_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (url_end) begin
      status      <= res_status;
      secure      <= res_secure;
      port_number <= res_port;
      host_offset <= res_host_offset;
      host_length <= res_host_length;
      path_offset <= res_path_offset;
    end
  end

endmodule
